/* design/bfd_pkg.sv */
`default_nettype none
package bfd_pkg;

   localparam int PIX_W     = 8;
   localparam int CH_N      = 3;
   localparam int SUM_W     = 24;
   localparam int SCALE_W   = 5;
   localparam int DIM_W     = 11;
   localparam int AREA_W    = 2 * SCALE_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [SCALE_W-1:0] SCALE_RST = 5'd1;
   localparam logic [DIM_W-1:0]   DIM_RST   = 11'd1024;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE,
      CSR_SRC_WIDTH,
      CSR_SRC_HEIGHT
   } csr_idx_type;

   // Channel order in the packed vectors: index 0 red, 1 green, 2 blue.
   typedef logic [CH_N-1:0][PIX_W-1:0] pix_type;
   typedef logic [CH_N-1:0][SUM_W-1:0] sum_vec_type;

   typedef struct packed {
      logic active;
      logic first;
      logic last;
      logic frame_end;
   } acc_ctl_type;

endpackage
`default_nettype wire

/* design/bfd_ifs.sv */
`default_nettype none
interface bfd_req_if;
   import bfd_pkg::*;
   logic             valid;
   logic             ready;
   logic             frame_start;
   logic [PIX_W-1:0] red_in;
   logic [PIX_W-1:0] green_in;
   logic [PIX_W-1:0] blue_in;

   modport source (output valid, frame_start, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, frame_start, red_in, green_in, blue_in, output ready);
endinterface

interface bfd_rsp_if;
   import bfd_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red_out;
   logic [PIX_W-1:0] green_out;
   logic [PIX_W-1:0] blue_out;
   logic             frame_end;

   modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface
`default_nettype wire

/* design/box_filter_downscale_top.sv */
// A block result passes the column-sum stage, the divider stages and the output register.
// Throughput: one pixel per cycle while the output is not stalled and the geometry is idle,
// set by the column-sum memory read-modify-write (with write forwarding) and the 8-stage
// averaging divider; both are fully pipelined. After reset and after every configuration
// write, input transfers are held off while the geometry is divided.
// Reset is synchronous, active high: counters, pipeline valids and configuration registers return to defaults.
`default_nettype none
module box_filter_downscale_top #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_SCALE = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   bfd_req_if.sink                        req_chan,
   bfd_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [bfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfd_pkg::DIM_W-1:0]      csr_wdata
);
   import bfd_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int PW = $clog2(MAX_SCALE);

   // Geometry derived from the configuration registers.
   logic               geom_busy;
   logic [SCALE_W-1:0] scale_eff;
   logic [AREA_W-1:0]  area;
   logic [WW-1:0]      width_eff, out_width, whole_width;
   logic [DIM_W-1:0]   height_eff, whole_height;

   // Raster position counters.
   logic [CW-1:0]      sc_ff, sc_in, sc;
   logic [DIM_W-1:0]   sr_ff, sr_in, sr;
   logic [PW-1:0]      cp_ff, cp_in, cp;
   logic [PW-1:0]      rp_ff, rp_in, rp;
   logic [CW-1:0]      oc_ff, oc_in, oc;
   logic               cp_last, rp_last;

   logic               advance;
   logic               in_accept;
   acc_ctl_type        ctl;
   pix_type            in_pix;

   logic               acc_valid;
   sum_vec_type        acc_sums;
   logic               acc_fend;

   logic               avg_valid;
   pix_type            avg_pix;
   logic               avg_fend;

   logic               out_valid_ff;
   pix_type            out_pix_ff;
   logic               out_fend_ff;
   logic               out_load;

   bfd_geom #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE)
   ) u_geom (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .busy         (geom_busy),
      .scale_eff    (scale_eff),
      .area         (area),
      .width_eff    (width_eff),
      .out_width    (out_width),
      .whole_width  (whole_width),
      .height_eff   (height_eff),
      .whole_height (whole_height)
   );

   // The whole pipeline moves together. It only halts when the divider holds a
   // finished average and the output register still holds one nobody has taken.
   assign advance   = !(avg_valid && out_valid_ff && !rsp_chan.ready);
   assign in_accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = advance && !geom_busy;

   // A frame start clears the counters before the pixel is placed.
   always_comb begin
      sc = req_chan.frame_start ? '0 : sc_ff;
      sr = req_chan.frame_start ? '0 : sr_ff;
      cp = req_chan.frame_start ? '0 : cp_ff;
      rp = req_chan.frame_start ? '0 : rp_ff;
      oc = req_chan.frame_start ? '0 : oc_ff;

      cp_last = 32'(cp) + 32'd1 >= 32'(scale_eff);
      rp_last = 32'(rp) + 32'd1 >= 32'(scale_eff);

      // Only pixels inside the whole-block area contribute to a sum.
      ctl.active    = (32'(sc) < 32'(whole_width)) && (sr < whole_height) &&
                      (32'(oc) < 32'(out_width));
      ctl.first     = (cp == '0) && (rp == '0);
      ctl.last      = cp_last && rp_last;
      ctl.frame_end = (32'(oc) + 32'd1 >= 32'(out_width)) &&
                      (32'(sr) + 32'd1 >= 32'(whole_height));

      in_pix[0] = req_chan.red_in;
      in_pix[1] = req_chan.green_in;
      in_pix[2] = req_chan.blue_in;

      // Step to the next raster position; rows and frames wrap by themselves.
      sc_in = sc;
      sr_in = sr;
      cp_in = cp;
      rp_in = rp;
      oc_in = oc;
      if (32'(sc) + 32'd1 >= 32'(width_eff)) begin
         sc_in = '0;
         cp_in = '0;
         oc_in = '0;
         if (32'(sr) + 32'd1 >= 32'(height_eff)) begin
            sr_in = '0;
            rp_in = '0;
         end else begin
            sr_in = sr + DIM_W'(1);
            rp_in = rp_last ? '0 : rp + PW'(1);
         end
      end else begin
         sc_in = sc + CW'(1);
         if (cp_last) begin
            cp_in = '0;
            oc_in = oc + CW'(1);
         end else begin
            cp_in = cp + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff <= '0;
         sr_ff <= '0;
         cp_ff <= '0;
         rp_ff <= '0;
         oc_ff <= '0;
      end else if (in_accept) begin
         sc_ff <= sc_in;
         sr_ff <= sr_in;
         cp_ff <= cp_in;
         rp_ff <= rp_in;
         oc_ff <= oc_in;
      end
   end

   // The output column addresses one entry of partial sums per block column.
   bfd_sums #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_sums (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_accept     (in_accept),
      .in_addr       (oc),
      .in_ctl        (ctl),
      .in_pix        (in_pix),
      .out_valid     (acc_valid),
      .out_sums      (acc_sums),
      .out_frame_end (acc_fend)
   );

   bfd_avg u_avg (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (acc_valid),
      .in_sums       (acc_sums),
      .in_frame_end  (acc_fend),
      .area          (area),
      .out_valid     (avg_valid),
      .out_avg       (avg_pix),
      .out_frame_end (avg_fend)
   );

   // Output register: a finished average waits here for its transfer while
   // the pipeline keeps taking pixels as long as the divider tail is empty.
   assign out_load = advance && avg_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_pix_ff  <= avg_pix;
         out_fend_ff <= avg_fend;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.red_out   = out_pix_ff[0];
   assign rsp_chan.green_out = out_pix_ff[1];
   assign rsp_chan.blue_out  = out_pix_ff[2];
   assign rsp_chan.frame_end = out_fend_ff;

endmodule
`default_nettype wire

/* design/bfd_geom.sv */
`default_nettype none
module bfd_geom #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_SCALE = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bfd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bfd_pkg::DIM_W-1:0]           csr_wdata,
   output logic                                busy,
   output logic [bfd_pkg::SCALE_W-1:0]         scale_eff,
   output logic [bfd_pkg::AREA_W-1:0]          area,
   output logic [$clog2(MAX_WIDTH+1)-1:0]      width_eff,
   output logic [$clog2(MAX_WIDTH+1)-1:0]      out_width,
   output logic [$clog2(MAX_WIDTH+1)-1:0]      whole_width,
   output logic [bfd_pkg::DIM_W-1:0]           height_eff,
   output logic [bfd_pkg::DIM_W-1:0]           whole_height
);
   import bfd_pkg::*;

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int DW    = (WW > DIM_W) ? WW : DIM_W;
   localparam int CNT_W = $clog2(DW + 1);

   logic [SCALE_W-1:0] scale_ff;
   logic [DIM_W-1:0]   src_width_ff;
   logic [DIM_W-1:0]   src_height_ff;
   logic               pending_ff;
   logic               busy_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [SCALE_W-1:0] rem_w_ff, rem_h_ff, rem_w_in, rem_h_in;
   logic [DW-1:0]      quo_w_ff, quo_h_ff, quo_w_in, quo_h_in;
   logic [AREA_W-1:0]  area_ff;
   logic [SCALE_W:0]   rem_w_sh, rem_h_sh;
   logic               ge_w, ge_h;

   always_comb begin
      if (scale_ff == '0) begin
         scale_eff = SCALE_W'(1);
      end else if (32'(scale_ff) > MAX_SCALE) begin
         scale_eff = SCALE_W'(MAX_SCALE);
      end else begin
         scale_eff = scale_ff;
      end
      if (src_width_ff == '0) begin
         width_eff = WW'(1);
      end else if (32'(src_width_ff) > MAX_WIDTH) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(src_width_ff);
      end
      height_eff = (src_height_ff == '0) ? DIM_W'(1) : src_height_ff;
   end

   // One quotient bit per cycle for both dimensions.
   always_comb begin
      rem_w_sh = {rem_w_ff, quo_w_ff[DW-1]};
      rem_h_sh = {rem_h_ff, quo_h_ff[DW-1]};
      ge_w     = rem_w_sh >= {1'b0, scale_eff};
      ge_h     = rem_h_sh >= {1'b0, scale_eff};
      rem_w_in = ge_w ? SCALE_W'(rem_w_sh - {1'b0, scale_eff}) : SCALE_W'(rem_w_sh);
      rem_h_in = ge_h ? SCALE_W'(rem_h_sh - {1'b0, scale_eff}) : SCALE_W'(rem_h_sh);
      quo_w_in = {quo_w_ff[DW-2:0], ge_w};
      quo_h_in = {quo_h_ff[DW-2:0], ge_h};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= SCALE_RST;
         src_width_ff  <= DIM_RST;
         src_height_ff <= DIM_RST;
         pending_ff    <= 1'b1;
         busy_ff       <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SCALE:      scale_ff      <= csr_wdata[SCALE_W-1:0];
               CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
               CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
               default: ;
            endcase
            pending_ff <= 1'b1;
         end else if (pending_ff) begin
            pending_ff <= 1'b0;
            busy_ff    <= 1'b1;
            cnt_ff     <= CNT_W'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pending_ff) begin
         rem_w_ff <= '0;
         rem_h_ff <= '0;
         quo_w_ff <= DW'(width_eff);
         quo_h_ff <= DW'(height_eff);
         area_ff  <= AREA_W'(scale_eff) * AREA_W'(scale_eff);
      end else if (busy_ff) begin
         rem_w_ff <= rem_w_in;
         rem_h_ff <= rem_h_in;
         quo_w_ff <= quo_w_in;
         quo_h_ff <= quo_h_in;
      end
   end

   assign busy         = pending_ff | busy_ff;
   assign area         = area_ff;
   assign out_width    = WW'(quo_w_ff);
   assign whole_width  = width_eff - WW'(rem_w_ff);
   assign whole_height = height_eff - DIM_W'(rem_h_ff);

endmodule
`default_nettype wire

/* design/bfd_sums.sv */
`default_nettype none
module bfd_sums #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_accept,
   input  logic [$clog2(MAX_WIDTH)-1:0]  in_addr,
   input  bfd_pkg::acc_ctl_type          in_ctl,
   input  bfd_pkg::pix_type              in_pix,
   output logic                          out_valid,
   output bfd_pkg::sum_vec_type          out_sums,
   output logic                          out_frame_end
);
   import bfd_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   sum_vec_type       sums_mem_ff [MAX_WIDTH];
   sum_vec_type       rd_ff;
   logic              s1_valid_ff;
   acc_ctl_type       s1_ctl_ff;
   logic [AW-1:0]     s1_addr_ff;
   pix_type           s1_pix_ff;
   logic              fwd_hit_ff;
   sum_vec_type       fwd_data_ff;
   sum_vec_type       base;
   sum_vec_type       sums;
   logic              wr_en;

   // The entry written at an edge is the one read at the same edge when two
   // pixels of one block follow each other; the write data is forwarded.
   always_comb begin
      if (s1_ctl_ff.first) begin
         base = '0;
      end else if (fwd_hit_ff) begin
         base = fwd_data_ff;
      end else begin
         base = rd_ff;
      end
      for (int c = 0; c < CH_N; c++) begin
         sums[c] = base[c] + SUM_W'(s1_pix_ff[c]);
      end
   end

   assign wr_en = advance && s1_valid_ff && s1_ctl_ff.active;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sums_mem_ff[s1_addr_ff] <= sums;
      end
      if (in_accept) begin
         rd_ff <= sums_mem_ff[in_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_accept;
         fwd_hit_ff  <= wr_en && in_accept && (in_addr == s1_addr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fwd_data_ff <= sums;
      end
      if (in_accept) begin
         s1_ctl_ff  <= in_ctl;
         s1_addr_ff <= in_addr;
         s1_pix_ff  <= in_pix;
      end
   end

   assign out_valid     = s1_valid_ff && s1_ctl_ff.active && s1_ctl_ff.last;
   assign out_sums      = sums;
   assign out_frame_end = s1_ctl_ff.frame_end;

endmodule
`default_nettype wire

/* design/bfd_avg.sv */
`default_nettype none
module bfd_avg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  bfd_pkg::sum_vec_type         in_sums,
   input  logic                         in_frame_end,
   input  logic [bfd_pkg::AREA_W-1:0]   area,
   output logic                         out_valid,
   output bfd_pkg::pix_type             out_avg,
   output logic                         out_frame_end
);
   import bfd_pkg::*;

   localparam int NST = PIX_W;

   logic              valid_ff [NST+1];
   logic              valid_in [NST+1];
   sum_vec_type       rem_ff   [NST+1];
   sum_vec_type       rem_in   [NST+1];
   pix_type           quo_ff   [NST+1];
   pix_type           quo_in   [NST+1];
   logic [CH_N-1:0]   sat_ff   [NST+1];
   logic [CH_N-1:0]   sat_in   [NST+1];
   logic              fend_ff  [NST+1];
   logic              fend_in  [NST+1];

   // Restoring division, one quotient bit per stage, most significant first.
   // A sum of 256 areas or more saturates, which the first stage detects.
   always_comb begin
      logic [SUM_W-1:0] dsh;
      logic             ge;
      valid_in[0] = in_valid;
      rem_in[0]   = in_sums;
      quo_in[0]   = '0;
      sat_in[0]   = '0;
      fend_in[0]  = in_frame_end;
      for (int k = 0; k < NST; k++) begin
         valid_in[k+1] = valid_ff[k];
         fend_in[k+1]  = fend_ff[k];
         dsh = SUM_W'(area) << (NST - 1 - k);
         for (int c = 0; c < CH_N; c++) begin
            ge = rem_ff[k][c] >= dsh;
            rem_in[k+1][c] = ge ? rem_ff[k][c] - dsh : rem_ff[k][c];
            quo_in[k+1][c] = {quo_ff[k][c][PIX_W-2:0], ge};
            sat_in[k+1][c] = sat_ff[k][c] |
                             ((k == 0) && (rem_ff[k][c] >= (SUM_W'(area) << NST)));
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NST; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= NST; k++) begin
            rem_ff[k]  <= rem_in[k];
            quo_ff[k]  <= quo_in[k];
            sat_ff[k]  <= sat_in[k];
            fend_ff[k] <= fend_in[k];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < CH_N; c++) begin
         out_avg[c] = sat_ff[NST][c] ? '1 : quo_ff[NST][c];
      end
   end

   assign out_valid     = valid_ff[NST];
   assign out_frame_end = fend_ff[NST];

endmodule
`default_nettype wire

/* design/bfd_chk.sv */
`default_nettype none
module bfd_chk (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_we
);

   // A result waiting for its transfer stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before its transfer");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A configuration write holds off input while the geometry is recomputed.
   assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("input taken right after a configuration write");

   // The geometry is recomputed after reset before any pixel is taken.
   assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("input taken right after reset");

endmodule

bind box_filter_downscale_top bfd_chk u_bfd_chk (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .csr_we    (csr_we)
);
`default_nettype wire

/* tb/box_filter_downscale_top_test.sv */
module box_filter_downscale_top_test;
   import bfd_pkg::*;

   localparam int MAX_WIDTH       = 1024;
   localparam int MAX_SCALE       = 16;
   // Drain time for results to pass the column-sum stage, the divider stages and the output register, with margin.
   localparam int PIPE_DRAIN      = 16;
   localparam int CYCLE_LIMIT     = 1000000;
   // The stimulus stops once this many pixels have been queued in total.
   localparam int STIMULUS_PIXELS = 1850;

   // One source pixel as the sender sees it. Channel 0 is red, 1 green, 2 blue.
   typedef struct packed {
      logic    frame_start;
      pix_type color;
   } src_pixel_type;

   // One averaged output pixel.
   typedef struct packed {
      pix_type color;
      logic    frame_end;
   } avg_pixel_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   csr_idx_type csr_index;
   logic [DIM_W-1:0] csr_wdata;

   bfd_req_if req_if ();
   bfd_rsp_if rsp_if ();

   box_filter_downscale_top #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Pixels waiting to be offered, and block averages waiting to come back.
   src_pixel_type pending_pixels [$];
   avg_pixel_type expected_avgs [$];
   int unsigned   pixels_queued   = 0;
   int unsigned   pixels_accepted = 0;
   int unsigned   mismatches      = 0;

   // Handshake pacing. The steady flags switch off the random gaps for a whole phase so
   // that back-to-back stretches occur as well.
   logic pixel_taken   = 1'b0;
   int   send_gap      = 0;
   int   sink_gap      = 0;
   bit   sender_steady = 1'b0;
   bit   sink_steady   = 1'b0;

   // Our own copy of the geometry registers and of the downscaler state.
   logic [SCALE_W-1:0] cfg_scale;
   logic [DIM_W-1:0]   cfg_width;
   logic [DIM_W-1:0]   cfg_height;
   sum_vec_type        column_sums [MAX_WIDTH];
   logic [9:0]         src_col;
   logic [10:0]        src_row;
   logic [3:0]         col_phase;
   logic [3:0]         row_phase;
   logic [13:0]        out_col;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Channel levels lean toward the two ends of the range so that full-scale sums occur.
   function automatic logic [PIX_W-1:0] random_level();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return PIX_W'($urandom_range(0, 255));
   endfunction

   // Number of source pixels in one frame after the width and height are clamped.
   function automatic int unsigned frame_pixels(input logic [DIM_W-1:0] w, h);
      int unsigned eff_w;
      int unsigned eff_h;
      eff_w = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
      eff_h = (h == 0) ? 1 : h;
      return eff_w * eff_h;
   endfunction

   task automatic restart_position();
      src_col   = '0;
      src_row   = '0;
      col_phase = '0;
      row_phase = '0;
      out_col   = '0;
   endtask

   // Folds one accepted source pixel into the column sums and queues the block average
   // when the pixel closes a block.
   task automatic fold_pixel(input src_pixel_type px);
      int unsigned   s;
      int unsigned   w;
      int unsigned   h;
      int unsigned   out_w;
      int unsigned   out_h;
      int unsigned   quot;
      int            c;
      logic          first;
      avg_pixel_type avg;

      // A scale of zero acts as one, and anything past the largest supported scale is
      // clamped; the same goes for a zero or oversized width, and for a zero height.
      s = (cfg_scale == 0) ? 1 : ((cfg_scale > MAX_SCALE) ? MAX_SCALE : cfg_scale);
      w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
      h = (cfg_height == 0) ? 1 : cfg_height;
      out_w = w / s;
      out_h = h / s;

      if (px.frame_start) restart_position();

      // Only pixels inside the whole-block area contribute; the remnant columns and rows
      // are swallowed without effect.
      if (src_col < out_w * s && src_row < out_h * s && out_col < out_w &&
          out_col < MAX_WIDTH) begin
         first = (col_phase == 0) && (row_phase == 0);
         for (c = 0; c < CH_N; c++) begin
            column_sums[out_col][c] = (first ? '0 : column_sums[out_col][c]) + px.color[c];
         end
         if (col_phase + 1 >= s && row_phase + 1 >= s) begin
            for (c = 0; c < CH_N; c++) begin
               quot = column_sums[out_col][c] / (s * s);
               avg.color[c] = (quot > 255) ? 8'd255 : quot[PIX_W-1:0];
            end
            avg.frame_end = (out_col + 1 >= out_w) && (src_row + 1 >= out_h * s);
            expected_avgs.push_back(avg);
         end
      end

      // Step to the next raster position. Counters that sit at or past a limit that was
      // just lowered wrap here as well.
      if (src_col + 1 >= w) begin
         src_col   = '0;
         col_phase = '0;
         out_col   = '0;
         if (src_row + 1 >= h) begin
            src_row   = '0;
            row_phase = '0;
         end else begin
            src_row   = src_row + 11'd1;
            row_phase = (row_phase + 1 >= s) ? '0 : row_phase + 4'd1;
         end
      end else begin
         src_col = src_col + 10'd1;
         if (col_phase + 1 >= s) begin
            col_phase = '0;
            out_col   = out_col + 14'd1;
         end else begin
            col_phase = col_phase + 4'd1;
         end
      end
   endtask

   // The monitor runs on the rising edge. An accepted pixel is folded into the
   // prediction before a result of the same edge is checked.
   always @(posedge clock) begin : result_check
      src_pixel_type seen_px;
      avg_pixel_type got;
      avg_pixel_type want;
      if (reset) begin
         restart_position();
         pixel_taken <= 1'b0;
      end else begin
         pixel_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            seen_px.frame_start = req_if.frame_start;
            seen_px.color[0]    = req_if.red_in;
            seen_px.color[1]    = req_if.green_in;
            seen_px.color[2]    = req_if.blue_in;
            fold_pixel(seen_px);
            pixels_accepted++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.color[0]  = rsp_if.red_out;
            got.color[1]  = rsp_if.green_out;
            got.color[2]  = rsp_if.blue_out;
            got.frame_end = rsp_if.frame_end;
            if (expected_avgs.size() == 0) begin
               $display("%0t: result with none expected: rgb %0d %0d %0d frame_end %0b",
                        $time, got.color[0], got.color[1], got.color[2], got.frame_end);
               mismatches++;
            end else begin
               want = expected_avgs.pop_front();
               if (got != want) begin
                  $display("%0t: expected rgb %0d %0d %0d frame_end %0b, got rgb %0d %0d %0d frame_end %0b",
                           $time, want.color[0], want.color[1], want.color[2], want.frame_end,
                           got.color[0], got.color[1], got.color[2], got.frame_end);
                  mismatches++;
               end
            end
         end
      end
   end

   // The sender works on the falling edge. A pixel stays on the bus until its transfer
   // has been seen on the previous rising edge; then an optional gap follows.
   always @(negedge clock) begin : pixel_driver
      src_pixel_type next_px;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || pixel_taken) begin
         if (send_gap > 0) begin
            req_if.valid <= 1'b0;
            send_gap     <= send_gap - 1;
         end else if (pending_pixels.size() != 0) begin
            next_px = pending_pixels.pop_front();
            req_if.valid       <= 1'b1;
            req_if.frame_start <= next_px.frame_start;
            req_if.red_in      <= next_px.color[0];
            req_if.green_in    <= next_px.color[1];
            req_if.blue_in     <= next_px.color[2];
            send_gap           <= sender_steady ? 0 : pick_gap();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // The receiver stalls at random, independent of whether a result is on offer.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
         rsp_if.ready <= 1'b0;
         sink_gap     <= sink_gap - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         sink_gap     <= sink_steady ? 0 : pick_gap();
      end
   end

   // Called from the stimulus thread only, right after a rising edge, so it never
   // competes with the driver for the queue.
   task automatic queue_pixel(input logic fs, input logic [PIX_W-1:0] r, g, b);
      src_pixel_type px;
      px.frame_start = fs;
      px.color[0]    = r;
      px.color[1]    = g;
      px.color[2]    = b;
      pending_pixels.push_back(px);
      pixels_queued++;
   endtask

   // Queues a run of random pixels. Frame starts go on the first pixel if asked for and on
   // most frame boundaries, so that some frames follow one another through the counters'
   // own wrap. With random restarts a stray frame start now and then cuts a frame short.
   task automatic queue_frames(input int unsigned count, input int unsigned frame_px,
                               input bit lead_restart, input bit random_restarts);
      logic fs;
      for (int unsigned i = 0; i < count; i++) begin
         fs = (i == 0) ? lead_restart : ((i % frame_px) == 0 && $urandom_range(0, 3) != 0);
         if (random_restarts && $urandom_range(0, 99) == 0) fs = 1'b1;
         queue_pixel(fs, random_level(), random_level(), random_level());
      end
   endtask

   // Waits until every queued pixel has been taken and every expected average has come
   // back, then lets the pipeline run dry, since a pixel that closes no block gives no
   // result to wait for.
   task automatic wait_for_idle();
      do @(negedge clock);
      while (pixels_accepted != pixels_queued || expected_avgs.size() != 0);
      repeat (PIPE_DRAIN) @(negedge clock);
   endtask

   // Writes all three geometry registers on consecutive edges while the block is idle.
   // The write enable stays high across the three writes and drops after the last.
   task automatic set_geometry(input logic [SCALE_W-1:0] s, input logic [DIM_W-1:0] w, h);
      wait_for_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_SCALE;
      csr_wdata <= DIM_W'(s);
      @(negedge clock);
      csr_index <= CSR_SRC_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= CSR_SRC_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_we     <= 1'b0;
      cfg_scale  = s;
      cfg_width  = w;
      cfg_height = h;
      @(posedge clock);
      sender_steady = ($urandom_range(0, 3) == 0);
      sink_steady   = ($urandom_range(0, 3) == 0);
   endtask

   // A new geometry followed by frames that begin with a frame start.
   task automatic run_phase(input logic [SCALE_W-1:0] s, input logic [DIM_W-1:0] w, h,
                            input int unsigned count);
      set_geometry(s, w, h);
      queue_frames(count, frame_pixels(w, h), 1'b1, 1'b1);
   endtask

   initial begin : stimulus
      logic [SCALE_W-1:0] s;
      logic [DIM_W-1:0]   w;
      logic [DIM_W-1:0]   h;
      int unsigned        eff_s;
      int unsigned        count;

      // Every input is at a known level from time zero on.
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_SCALE;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.frame_start = 1'b0;
      req_if.red_in      = '0;
      req_if.green_in    = '0;
      req_if.blue_in     = '0;
      rsp_if.ready       = 1'b0;
      cfg_scale          = SCALE_RST;
      cfg_width          = DIM_RST;
      cfg_height         = DIM_RST;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset geometry is a scale of one, so every pixel comes back unchanged. The
      // extreme levels on each channel go through first.
      queue_pixel(1'b1, 8'h00, 8'h00, 8'h00);
      queue_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);

      // Two-by-two blocks in a two-by-two frame: one full-scale block, then one whose sums
      // truncate on division. The second frame follows through the counters' wrap.
      set_geometry(5'd2, 11'd2, 11'd2);
      queue_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
      queue_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
      queue_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
      queue_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
      queue_pixel(1'b0, 8'h01, 8'hFF, 8'h03);
      queue_pixel(1'b0, 8'h00, 8'hFF, 8'h03);
      queue_pixel(1'b0, 8'h00, 8'hFF, 8'h03);
      queue_pixel(1'b0, 8'h02, 8'hFE, 8'h03);

      // Geometry changes in the middle of a frame. At a scale of one every pixel opens a
      // block of its own, so no column sum is read that this frame did not write. The
      // width shrinks below the current column, then the height below the current row;
      // the counters wrap on their next advance.
      set_geometry(5'd1, 11'd4, 11'd4);
      queue_frames(7, 16, 1'b1, 1'b0);
      set_geometry(5'd1, 11'd2, 11'd4);
      queue_frames(3, 8, 1'b0, 1'b0);
      set_geometry(5'd1, 11'd2, 11'd2);
      queue_frames(3, 4, 1'b0, 1'b0);

      // Register extremes: scale zero, scale past the largest supported one, zero width
      // and height, a width past the column memory that must clamp at its end, a tall
      // frame and the reset values written back explicitly.
      run_phase(5'd0, 11'd3, 11'd2, 12);
      run_phase(5'd31, 11'd16, 11'd16, 256);
      run_phase(5'd1, 11'd0, 11'd2, 6);
      run_phase(5'd1, 11'd3, 11'd0, 9);
      run_phase(5'd2, 11'd4, 11'd2047, 40);
      run_phase(5'd1, 11'd1, 11'd1, 5);
      run_phase(5'd1, 11'd1024, 11'd1024, 30);
      set_geometry(5'd1, 11'd2047, 11'd1);
      queue_frames(1040, 1024, 1'b1, 1'b0);

      // Random geometry, mostly small images with small scales and now and then a large
      // scale over an image just big enough for one block.
      while (pixels_queued < STIMULUS_PIXELS) begin
         if ($urandom_range(0, 19) == 0) begin
            s     = SCALE_W'($urandom_range(9, 31));
            eff_s = (s > MAX_SCALE) ? MAX_SCALE : s;
            w     = DIM_W'(eff_s + $urandom_range(0, 3));
            h     = DIM_W'(eff_s + $urandom_range(0, 2));
         end else begin
            s = SCALE_W'($urandom_range(0, 6));
            w = DIM_W'($urandom_range(0, 24));
            h = DIM_W'($urandom_range(0, 12));
         end
         count = frame_pixels(w, h) * $urandom_range(1, 3) + $urandom_range(0, 5);
         if (count > 360) count = 360;
         run_phase(s, w, h, count);
      end

      wait_for_idle();
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: a lost or stuck transfer ends the run here.
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

endmodule
